/* design/hcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types, constants and a lookup function of the credential checker.
// ----------------------------------------------------------------------------
package hcc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned TOK_LOW_W  = 64;
    localparam int unsigned TOK_HIGH_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_HIGH   = 2'd2;

    localparam logic [BYTE_W-1:0] STRUCT_MARK_LO = 8'hB0;
    localparam logic [BYTE_W-1:0] STRUCT_MARK_HI = 8'hBF;
    localparam logic [BYTE_W-1:0] HELLO_SIG      = 8'h01;
    localparam logic [BYTE_W-1:0] MAP_MARK_LO    = 8'hA0;
    localparam logic [BYTE_W-1:0] MAP_MARK_HI    = 8'hAF;
    localparam logic [BYTE_W-1:0] STR_MARK_LO    = 8'h80;
    localparam logic [BYTE_W-1:0] STR_MARK_HI    = 8'h8F;

    localparam logic [LEN_W-1:0] CRED_KEY_LEN = 4'd11;
    localparam logic [LEN_W-1:0] TOKEN_NONE   = 4'd15;

    typedef enum logic [2:0] {
        PH_STRUCT  = 3'd0,
        PH_SIG     = 3'd1,
        PH_MAP     = 3'd2,
        PH_KEYMARK = 3'd3,
        PH_KEY     = 3'd4,
        PH_VALMARK = 3'd5,
        PH_VAL     = 3'd6,
        PH_DONE    = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REQUIRED  = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    typedef struct packed {
        logic [LEN_W-1:0]  token_length;
        logic [BYTE_W-1:0] token_byte;
    } t_token_info;

    // Characters of the "credentials" key; positions past the key give zero.
    function automatic logic [BYTE_W-1:0] cred_char(input logic [LEN_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h72; // r
            4'd2:    c = 8'h65; // e
            4'd3:    c = 8'h64; // d
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h69; // i
            4'd8:    c = 8'h61; // a
            4'd9:    c = 8'h6C; // l
            4'd10:   c = 8'h73; // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* design/hcc_token_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_token_regs
// Token configuration registers and selection of the token byte to compare.
// ----------------------------------------------------------------------------
module hcc_token_regs
    import hcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [LEN_W-1:0]      i_byte_index,
    output t_token_info           o_token
);

    logic [LEN_W-1:0]      r_token_length;
    logic [TOK_LOW_W-1:0]  r_token_low;
    logic [TOK_HIGH_W-1:0] r_token_high;
    logic [BYTE_W-1:0]     n_token_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_length <= '0;
            r_token_low    <= '0;
            r_token_high   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TOKEN_LENGTH: r_token_length <= i_cfg_data[LEN_W-1:0];
                CFG_TOKEN_LOW:    r_token_low    <= i_cfg_data[TOK_LOW_W-1:0];
                CFG_TOKEN_HIGH:   r_token_high   <= i_cfg_data[TOK_HIGH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pick the byte at the current value position
    always_comb begin
        if (i_byte_index == TOKEN_NONE) begin
            n_token_byte = '0;
        end else if (!i_byte_index[3]) begin
            n_token_byte = r_token_low[{i_byte_index[2:0], 3'b000} +: BYTE_W];
        end else begin
            n_token_byte = r_token_high[{i_byte_index[2:0], 3'b000} +: BYTE_W];
        end
    end

    assign o_token.token_length = r_token_length;
    assign o_token.token_byte   = n_token_byte;

endmodule

/* design/hcc_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcc_parser
// Per-byte parse state of the HELLO message and status at the last byte.
// ----------------------------------------------------------------------------
module hcc_parser
    import hcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  t_token_info       i_token,
    output logic [LEN_W-1:0]  o_string_index,
    output t_status           o_status
);

    t_phase           r_phase,          n_phase;
    t_status          r_first_error,    n_first_error;
    logic             r_error_seen,     n_error_seen;
    logic [LEN_W-1:0] r_entries_left,   n_entries_left;
    logic [LEN_W-1:0] r_string_left,    n_string_left;
    logic [LEN_W-1:0] r_string_index,   n_string_index;
    logic             r_key_matches,    n_key_matches;
    logic             r_value_mismatch, n_value_mismatch;
    logic             r_credentials_ok, n_credentials_ok;
    logic             raise;
    t_status          raise_code;
    logic             finish;
    logic             str_mark_ok;

    assign str_mark_ok = (i_byte >= STR_MARK_LO) && (i_byte <= STR_MARK_HI);

    always_comb begin
        n_phase          = r_phase;
        n_first_error    = r_first_error;
        n_error_seen     = r_error_seen;
        n_entries_left   = r_entries_left;
        n_string_left    = r_string_left;
        n_string_index   = r_string_index;
        n_key_matches    = r_key_matches;
        n_value_mismatch = r_value_mismatch;
        n_credentials_ok = r_credentials_ok;
        raise            = 1'b0;
        raise_code       = ST_REQUIRED;
        finish           = 1'b0;

        case (r_phase)
            PH_STRUCT: begin
                if (i_byte < STRUCT_MARK_LO || i_byte > STRUCT_MARK_HI) begin
                    raise = 1'b1;
                end else begin
                    n_phase = PH_SIG;
                end
            end
            PH_SIG: begin
                if (i_byte != HELLO_SIG) begin
                    raise = 1'b1;
                end else begin
                    n_phase = PH_MAP;
                end
            end
            PH_MAP: begin
                if (i_byte < MAP_MARK_LO || i_byte > MAP_MARK_HI) begin
                    raise = 1'b1;
                end else begin
                    n_entries_left = i_byte[LEN_W-1:0];
                    n_phase = (i_byte[LEN_W-1:0] != '0) ? PH_KEYMARK : PH_DONE;
                end
            end
            PH_KEYMARK: begin
                if (!str_mark_ok) begin
                    raise      = 1'b1;
                    raise_code = ST_MALFORMED;
                end else begin
                    n_string_left  = i_byte[LEN_W-1:0];
                    n_string_index = '0;
                    n_key_matches  = (i_byte[LEN_W-1:0] == CRED_KEY_LEN);
                    n_phase = (i_byte[LEN_W-1:0] != '0) ? PH_KEY : PH_VALMARK;
                end
            end
            PH_KEY: begin
                if (r_key_matches && (r_string_index >= CRED_KEY_LEN
                        || i_byte != cred_char(r_string_index))) begin
                    n_key_matches = 1'b0;
                end
                n_string_index = r_string_index + 1'b1;
                n_string_left  = r_string_left - 1'b1;
                if (n_string_left == '0) begin
                    n_phase = PH_VALMARK;
                end
            end
            PH_VALMARK: begin
                if (!str_mark_ok) begin
                    raise      = 1'b1;
                    raise_code = ST_MALFORMED;
                end else begin
                    n_string_left    = i_byte[LEN_W-1:0];
                    n_string_index   = '0;
                    n_value_mismatch = (i_byte[LEN_W-1:0] != i_token.token_length);
                    if (i_byte[LEN_W-1:0] != '0) begin
                        n_phase = PH_VAL;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            PH_VAL: begin
                if (i_byte != i_token.token_byte) begin
                    n_value_mismatch = 1'b1;
                end
                n_string_index = r_string_index + 1'b1;
                n_string_left  = r_string_left - 1'b1;
                if (n_string_left == '0) begin
                    finish = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (finish) begin
            if (r_key_matches) begin
                n_credentials_ok = !n_value_mismatch;
            end
            n_key_matches  = 1'b0;
            n_entries_left = r_entries_left - 1'b1;
            n_phase = (n_entries_left != '0) ? PH_KEYMARK : PH_DONE;
        end

        if (raise) begin
            if (!r_error_seen) begin
                n_error_seen  = 1'b1;
                n_first_error = raise_code;
            end
            n_phase = PH_DONE;
        end

        // status as seen after this byte
        if (i_token.token_length == '0) begin
            o_status = ST_OK;
        end else if (n_error_seen) begin
            o_status = n_first_error;
        end else if (n_phase == PH_STRUCT || n_phase == PH_SIG || n_phase == PH_MAP) begin
            o_status = ST_REQUIRED;
        end else if (n_phase != PH_DONE) begin
            o_status = ST_MALFORMED;
        end else if (n_credentials_ok) begin
            o_status = ST_OK;
        end else begin
            o_status = ST_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase          <= PH_STRUCT;
            r_first_error    <= ST_OK;
            r_error_seen     <= 1'b0;
            r_entries_left   <= '0;
            r_string_left    <= '0;
            r_string_index   <= '0;
            r_key_matches    <= 1'b0;
            r_value_mismatch <= 1'b0;
            r_credentials_ok <= 1'b0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_first_error    <= n_first_error;
            r_error_seen     <= n_error_seen;
            r_entries_left   <= n_entries_left;
            r_string_left    <= n_string_left;
            r_string_index   <= n_string_index;
            r_key_matches    <= n_key_matches;
            r_value_mismatch <= n_value_mismatch;
            r_credentials_ok <= n_credentials_ok;
        end
    end

    assign o_string_index = r_string_index;

    a_error_ends_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_seen |-> r_phase == PH_DONE)
        else $error("error recorded while parse still active");

    a_no_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_error_seen |-> r_first_error == ST_OK)
        else $error("error code set without an error");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_phase == PH_STRUCT && !r_error_seen
            && !r_credentials_ok))
        else $error("message state not cleared after last byte");

    a_no_key_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STRUCT || r_phase == PH_SIG || r_phase == PH_MAP)
            |-> !r_key_matches)
        else $error("key match flag set before the map");

endmodule

/* design/hello_credential_checker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hello_credential_checker_core
// Streaming check of the credentials entry of a HELLO message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one payload byte per word, with
//   i_last_byte on the final byte. Output channel (o_valid / i_ready) carries
//   one o_auth_status word per message, produced at its last byte; other bytes
//   produce nothing.
//   Each accepted byte goes into an input register and is parsed from there;
//   the status of a last byte lands in the output register, which drives
//   o_valid. Throughput is one byte per cycle, but a last byte waits while
//   the output slot is occupied; the per-byte parse step is the only work.
//   If the receiver stalls, the output register holds the status; non-last
//   bytes keep flowing, and a further last byte waits in the input register,
//   holding o_ready low, until the output slot frees.
//   Synchronous reset clears the token registers, parse state and both
//   valid flags. Write the token registers through i_cfg_* while idle.
// ----------------------------------------------------------------------------
module hello_credential_checker_core
    import hcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_last_byte,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_auth_status
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_status           r_out_status;
    logic              out_free;
    logic              step;
    t_token_info       token;
    logic [LEN_W-1:0]  string_index;
    t_status           status;

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign o_ready  = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    hcc_token_regs u_token (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_byte_index (string_index),
        .o_token      (token)
    );

    hcc_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_token        (token),
        .o_string_index (string_index),
        .o_status       (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out_status <= status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_auth_status = r_out_status;

endmodule

/* dv/hello_credential_checker_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hello_credential_checker_core_tb
// Self-checking bench for the HELLO credential checker. Payload bytes go in as
// framed messages (directed header, map and token cases, then random traffic
// over several token settings). A local parser predicts each status word, and
// every status word that comes out is compared in order. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module hello_credential_checker_core_tb;
    import hcc_pkg::*;

    localparam int unsigned RUN_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [87:0] CRED_KEY = "credentials";

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [BYTE_W-1:0]     i_data_byte;
    logic                  i_last_byte;
    logic                  o_valid;
    logic                  i_ready;
    logic [1:0]            o_auth_status;

    hello_credential_checker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_auth_status (o_auth_status)
    );

    // token shadow
    logic [LEN_W-1:0]      tok_len;
    logic [TOK_LOW_W-1:0]  tok_lo;
    logic [TOK_HIGH_W-1:0] tok_hi;

    // parser shadow
    t_phase     cur_phase;
    t_status    err_code;
    logic       err_flag;
    logic [3:0] entries_todo;
    logic [3:0] str_todo;
    logic [3:0] str_pos;
    logic       key_is_cred;
    logic       val_differs;
    logic       cred_good;

    t_status        status_q[$];
    t_status        status_want;
    logic [7:0]     frame[$];
    int             mismatches;
    int             status_seen[4];
    int             bytes_sent;
    int             messages_sent;
    int             burst_left;
    int unsigned    cycle_count;
    int             rx_mode;
    int             rx_mode_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] key_char(input int p);
        return (p < 11) ? CRED_KEY[87 - 8 * p -: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] token_byte_at(input int i);
        if (i < 8) return tok_lo[8 * i +: 8];
        if (i < 15) return tok_hi[8 * (i - 8) +: 8];
        return 8'h00;
    endfunction

    task automatic clear_parse();
        cur_phase    = PH_STRUCT;
        err_code     = ST_OK;
        err_flag     = 1'b0;
        entries_todo = '0;
        str_todo     = '0;
        str_pos      = '0;
        key_is_cred  = 1'b0;
        val_differs  = 1'b0;
        cred_good    = 1'b0;
    endtask

    task automatic flag_error(input t_status code);
        if (!err_flag) begin
            err_flag = 1'b1;
            err_code = code;
        end
        cur_phase = PH_DONE;
    endtask

    task automatic close_entry();
        if (key_is_cred) cred_good = !val_differs;
        key_is_cred  = 1'b0;
        entries_todo = entries_todo - 4'd1;
        cur_phase    = (entries_todo != 0) ? PH_KEYMARK : PH_DONE;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        t_status st;
        case (cur_phase)
            PH_STRUCT: begin
                if (b < STRUCT_MARK_LO || b > STRUCT_MARK_HI) flag_error(ST_REQUIRED);
                else cur_phase = PH_SIG;
            end
            PH_SIG: begin
                if (b != HELLO_SIG) flag_error(ST_REQUIRED);
                else cur_phase = PH_MAP;
            end
            PH_MAP: begin
                if (b < MAP_MARK_LO || b > MAP_MARK_HI) begin
                    flag_error(ST_REQUIRED);
                end else begin
                    entries_todo = b[3:0];
                    cur_phase    = (b[3:0] != 0) ? PH_KEYMARK : PH_DONE;
                end
            end
            PH_KEYMARK: begin
                if (b < STR_MARK_LO || b > STR_MARK_HI) begin
                    flag_error(ST_MALFORMED);
                end else begin
                    str_todo    = b[3:0];
                    str_pos     = '0;
                    key_is_cred = (b[3:0] == CRED_KEY_LEN);
                    cur_phase   = (b[3:0] != 0) ? PH_KEY : PH_VALMARK;
                end
            end
            PH_KEY: begin
                if (key_is_cred && (str_pos >= CRED_KEY_LEN || b != key_char(str_pos)))
                    key_is_cred = 1'b0;
                str_pos  = str_pos + 4'd1;
                str_todo = str_todo - 4'd1;
                if (str_todo == 0) cur_phase = PH_VALMARK;
            end
            PH_VALMARK: begin
                if (b < STR_MARK_LO || b > STR_MARK_HI) begin
                    flag_error(ST_MALFORMED);
                end else begin
                    str_todo    = b[3:0];
                    str_pos     = '0;
                    val_differs = (b[3:0] != tok_len);
                    if (b[3:0] != 0) cur_phase = PH_VAL;
                    else close_entry();
                end
            end
            PH_VAL: begin
                if (b != token_byte_at(str_pos)) val_differs = 1'b1;
                str_pos  = str_pos + 4'd1;
                str_todo = str_todo - 4'd1;
                if (str_todo == 0) close_entry();
            end
            default: ;
        endcase
        if (last) begin
            if (tok_len == 0) st = ST_OK;
            else if (err_flag) st = err_code;
            else if (cur_phase <= PH_MAP) st = ST_REQUIRED;
            else if (cur_phase != PH_DONE) st = ST_MALFORMED;
            else st = cred_good ? ST_OK : ST_INVALID;
            status_q = {status_q, st};
            clear_parse();
        end
    endtask

    task automatic log_fault(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // predict on input words, check on output words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) absorb_byte(i_data_byte, i_last_byte);
            if (o_valid && i_ready) begin
                if (status_q.size() == 0) begin
                    log_fault($sformatf("unexpected status word %0d at cycle %0d",
                                        o_auth_status, cycle_count));
                end else begin
                    status_want = status_q.pop_front();
                    status_seen[status_want]++;
                    if (o_auth_status !== status_want)
                        log_fault($sformatf("status mismatch at cycle %0d: expected %0d got %0d",
                                            cycle_count, status_want, o_auth_status));
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(16, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= $urandom_range(0, 1);
            2:       i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= cycle_count[2];
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_TOKEN_LENGTH: tok_len = data[LEN_W-1:0];
            CFG_TOKEN_LOW:    tok_lo  = data;
            CFG_TOKEN_HIGH:   tok_hi  = data[TOK_HIGH_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_token(input logic [3:0] len, input logic [63:0] lo,
                             input logic [63:0] hi);
        logic [63:0] len_word;
        len_word      = rand64();
        len_word[3:0] = len;
        write_reg(CFG_TOKEN_LENGTH, len_word);
        write_reg(CFG_TOKEN_LOW, lo);
        write_reg(CFG_TOKEN_HIGH, hi);
    endtask

    // drop valid, drain every status word, then hold for the pipeline
    task automatic wait_idle();
        i_valid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
        messages_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        frame = {frame, b};
    endtask

    task automatic add_header(input int n_entries);
        put_byte(STRUCT_MARK_LO | 8'($urandom_range(0, 15)));
        put_byte(HELLO_SIG);
        put_byte(MAP_MARK_LO | 8'(n_entries));
    endtask

    task automatic add_cred_key();
        put_byte(STR_MARK_LO | 8'(CRED_KEY_LEN));
        for (int i = 0; i < 11; i++) put_byte(key_char(i));
    endtask

    task automatic add_str(input int n);
        put_byte(STR_MARK_LO | 8'(n));
        repeat (n) put_byte(8'($urandom()));
    endtask

    task automatic add_token(input bit flip);
        if (flip && tok_len == 0) begin
            add_str($urandom_range(1, 3));
            return;
        end
        put_byte(STR_MARK_LO | 8'(tok_len));
        for (int i = 0; i < tok_len; i++) put_byte(token_byte_at(i));
        if (flip)
            frame[frame.size() - 1 - $urandom_range(0, tok_len - 1)] ^=
                8'(1 << $urandom_range(0, 7));
    endtask

    function automatic int small_len();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
    endfunction

    task automatic add_entry();
        int r;
        int v;
        int n;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            add_cred_key();
        end else if (r < 5) begin
            add_cred_key();
            frame[frame.size() - 1 - $urandom_range(0, 10)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (r < 6) begin
            n = $urandom_range(0, 1) ? 10 : 12;
            put_byte(STR_MARK_LO | 8'(n));
            for (int i = 0; i < n; i++) put_byte(i < 11 ? key_char(i) : 8'($urandom()));
        end else begin
            add_str(small_len());
        end
        v = $urandom_range(0, 9);
        if (v < 5) add_token(1'b0);
        else if (v < 7) add_token(1'b1);
        else add_str(small_len());
    endtask

    task automatic build_message();
        int kind;
        int n_ent;
        int cut;
        frame.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            repeat ($urandom_range(1, 5)) put_byte(8'($urandom()));
            return;
        end
        n_ent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
        add_header(n_ent);
        repeat (n_ent) add_entry();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom()));
        if (kind >= 85) begin
            frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom());
        end else if (kind >= 80) begin
            frame[$urandom_range(0, 2)] = 8'($urandom());
        end else if (kind >= 65) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut) void'(frame.pop_back());
        end
    endtask

    task automatic test_auth_disabled();
        frame.delete();
        add_header(1);
        add_cred_key();
        add_str(3);
        send_frame();
        frame = '{8'h00};
        send_frame();
    endtask

    task automatic test_header_errors();
        wait_idle();
        set_token(4'd4, rand64(), rand64());
        frame = '{8'hAF};
        send_frame();
        frame = '{8'hC0, 8'h01, 8'hA0};
        send_frame();
        frame = '{8'hB0, 8'h02, 8'hA0};
        send_frame();
        frame = '{8'hBF, 8'h01, 8'h9F};
        send_frame();
        frame = '{8'hB5, 8'h01, 8'hB0};
        send_frame();
        frame = '{8'hB0};
        send_frame();
        frame = '{8'hBF, 8'h01};
        send_frame();
    endtask

    task automatic test_map_errors();
        frame = '{8'hB0, 8'h01, 8'hA1, 8'h90, 8'h61, 8'h62};
        send_frame();
        frame = '{8'hB3, 8'h01, 8'hA2, 8'h81, 8'h78, 8'h7F};
        add_cred_key();
        add_token(1'b0);
        send_frame();
        frame.delete();
        add_header(2);
        add_cred_key();
        repeat (9) void'(frame.pop_back());
        send_frame();
        frame = '{8'hBF, 8'h01, 8'hA1};
        send_frame();
    endtask

    task automatic test_credential_match();
        frame = '{8'hB0, 8'h01, 8'hA0};
        send_frame();
        frame.delete();
        add_header(1);
        add_str(5);
        add_token(1'b0);
        send_frame();
        frame.delete();
        add_header(1);
        add_cred_key();
        add_token(1'b0);
        send_frame();
        frame.delete();
        add_header(1);
        add_cred_key();
        add_str(tok_len + 1);
        send_frame();
        frame.delete();
        add_header(1);
        add_cred_key();
        add_token(1'b1);
        send_frame();
        frame.delete();
        add_header(2);
        add_cred_key();
        add_token(1'b0);
        add_cred_key();
        add_token(1'b1);
        send_frame();
        frame.delete();
        add_header(2);
        add_cred_key();
        add_token(1'b1);
        add_cred_key();
        add_token(1'b0);
        send_frame();
        frame.delete();
        add_header(1);
        put_byte(STR_MARK_LO | 8'd12);
        for (int i = 0; i < 11; i++) put_byte(key_char(i));
        put_byte(8'h73);
        add_token(1'b0);
        send_frame();
        frame.delete();
        add_header(1);
        add_cred_key();
        add_token(1'b0);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h8F);
        send_frame();
    endtask

    task automatic test_config_extremes();
        wait_idle();
        set_token(4'd15, '1, '1);
        frame.delete();
        add_header(1);
        add_cred_key();
        add_token(1'b0);
        send_frame();
        wait_idle();
        set_token(4'd15, '0, '0);
        frame.delete();
        add_header(2);
        add_str(0);
        add_str(0);
        add_cred_key();
        add_token(1'b0);
        send_frame();
        wait_idle();
        set_token(4'd1, rand64(), rand64());
        write_reg(CFG_UNUSED, '1);
        frame.delete();
        add_header(1);
        add_cred_key();
        add_token(1'b0);
        send_frame();
        frame.delete();
        add_header(15);
        repeat (15) add_str(0);
        send_frame();
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        logic [3:0] len;
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0:       len = 4'd15;
                1:       len = 4'd1;
                2:       len = 4'd0;
                default: len = 4'($urandom_range(1, 15));
            endcase
            set_token(len, rand64(), rand64());
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < 210) begin
                build_message();
                send_frame();
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_TOKEN_LENGTH;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_data_byte  <= '0;
        i_last_byte  <= 1'b0;
        i_ready      <= 1'b0;
        tok_len       = '0;
        tok_lo        = '0;
        tok_hi        = '0;
        mismatches    = 0;
        bytes_sent    = 0;
        messages_sent = 0;
        burst_left    = 0;
        cycle_count   = 0;
        rx_mode       = 0;
        rx_mode_left  = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        clear_parse();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_auth_disabled();
        test_header_errors();
        test_map_errors();
        test_credential_match();
        test_config_extremes();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d messages (%0d payload bytes) over several token settings",
                 messages_sent, bytes_sent);
        $display("Status words: ok %0d, required %0d, malformed %0d, invalid %0d; faults %0d",
                 status_seen[ST_OK], status_seen[ST_REQUIRED], status_seen[ST_MALFORMED],
                 status_seen[ST_INVALID], mismatches);
        if (mismatches == 0 && status_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/hcc_pkg.sv
design/hcc_token_regs.sv
design/hcc_parser.sv
design/hello_credential_checker_core.sv
dv/hello_credential_checker_core_tb.sv
